@@ rtl/blrc_pkg.sv @@
// ----------------------------------------------------------------------------
// blrc_pkg: backlight level remap controller package
// Shared request, status, register, slot and state codes, panel writes, reset values, divider sizing.
// ----------------------------------------------------------------------------
package blrc_pkg;

  // Request codes
  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_ON     = 2'd1,
    REQ_OFF    = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_GATED   = 2'd1,
    ST_SAME    = 2'd2,
    ST_OFF     = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_USER_DEFAULT  = 3'd0,
    CFG_USER_MINIMUM  = 3'd1,
    CFG_USER_MAXIMUM  = 3'd2,
    CFG_PANEL_DEFAULT = 3'd3,
    CFG_PANEL_MINIMUM = 3'd4,
    CFG_PANEL_MAXIMUM = 3'd5,
    CFG_DIM_THRESHOLD = 3'd6
  } cfg_idx_e;

  // Write slots of one sequence
  typedef enum logic [1:0] {
    SLOT_DIM   = 2'd0,
    SLOT_MODE  = 2'd1,
    SLOT_LEVEL = 2'd2
  } slot_e;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RANGE = 6'b000010,
    S_DIV   = 6'b000100,
    S_FIX   = 6'b001000,
    S_CMP   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  // Panel register writes
  localparam logic [15:0] ADDR_DIM   = 16'h5300;
  localparam logic [15:0] ADDR_MODE  = 16'h5500;
  localparam logic [15:0] ADDR_LEVEL = 16'h5100;
  localparam logic [7:0]  DATA_DIM   = 8'h2C;
  localparam logic [7:0]  DATA_MODE  = 8'h00;

  // Reset values
  localparam logic [7:0] RST_USER_DEFAULT  = 8'd143;
  localparam logic [7:0] RST_USER_MINIMUM  = 8'd30;
  localparam logic [7:0] RST_USER_MAXIMUM  = 8'd255;
  localparam logic [7:0] RST_PANEL_DEFAULT = 8'd102;
  localparam logic [7:0] RST_PANEL_MINIMUM = 8'd6;
  localparam logic [7:0] RST_PANEL_MAXIMUM = 8'd255;
  localparam logic [7:0] RST_DIM_THRESHOLD = 8'd9;
  localparam logic [7:0] RST_SAVED_LEVEL   = 8'd143;

  // Divider sizing: dividend magnitude width and step counter width
  localparam int unsigned NumW  = 16;
  localparam int unsigned CntW  = 4;

endpackage

@@ rtl/blrc_intf.sv @@
// ----------------------------------------------------------------------------
// blrc_intf: backlight controller channels
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface blrc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] level_request;

  modport source (output valid, output req_type, output level_request, input ready);
  modport sink   (input valid, input req_type, input level_request, output ready);
endinterface

interface blrc_rsp_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [15:0] reg_addr;
  logic [7:0]  reg_data;
  logic [1:0]  status;
  logic [7:0]  stored_level;
  logic        last;

  modport source (output valid, output write_valid, output reg_addr, output reg_data,
                  output status, output stored_level, output last, input ready);
  modport sink   (input valid, input write_valid, input reg_addr, input reg_data,
                  input status, input stored_level, input last, output ready);
endinterface

interface blrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_idx;
  logic [7:0] wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

@@ rtl/backlight_level_remap_controller.sv @@
// ----------------------------------------------------------------------------
// backlight_level_remap_controller: piecewise linear backlight remapper
// Remaps user levels onto the panel range and emits panel register writes.
// ----------------------------------------------------------------------------
// Path: an interpolating request passes range check, the 16-step shared restoring
// divider, fix and compare before its first result beat; a flat piece or a zero
// divisor passes range check and compare; gated and off requests go straight to emit;
// output stalls hold the beats. One request at a time, 1 to 3 beats each, the unused
// code accepted with no beat; ready returns in the cycle after the last beat loads.
// Reset: asynchronous, active low; configuration and backlight state take their
// documented reset values, no result pending.
module backlight_level_remap_controller (
  input  logic clk_i,
  input  logic rst_ni,
  blrc_req_if.sink   req_i,
  blrc_rsp_if.source rsp_o,
  blrc_cfg_if.sink   cfg_i
);
  import blrc_pkg::*;

  // Configuration registers
  logic [7:0] user_def_q, user_min_q, user_max_q;
  logic [7:0] panel_def_q, panel_min_q, panel_max_q, dim_thr_q;

  // Backlight state
  logic       enabled_q;
  logic [7:0] last_q;
  logic       dim_q;
  logic [7:0] saved_q;

  // Sequencer and working registers
  state_e          state_q;
  logic [7:0]      lvl_q;
  logic            is_on_q;
  logic [7:0]      pl_q;
  logic [7:0]      off_q;
  logic            neg_q;
  logic [NumW-1:0] quo_q;
  logic [7:0]      rem_q;
  logic [7:0]      den_q;
  logic [CntW-1:0] cnt_q;
  logic            wr_q;
  status_e         stat_q;
  slot_e           slot_q;

  // Output register
  logic        out_vld_q;
  logic        out_wr_q;
  logic [15:0] out_addr_q;
  logic [7:0]  out_data_q;
  logic [1:0]  out_stat_q;
  logic [7:0]  out_lvl_q;
  logic        out_last_q;

  logic in_acc;
  logic out_load;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_load    = (state_q == S_EMIT) && (!out_vld_q || rsp_o.ready);

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.write_valid  = out_wr_q;
  assign rsp_o.reg_addr     = out_addr_q;
  assign rsp_o.reg_data     = out_data_q;
  assign rsp_o.status       = out_stat_q;
  assign rsp_o.stored_level = out_lvl_q;
  assign rsp_o.last         = out_last_q;

  // Range selection and product for the interpolating piece
  logic              upper;
  logic signed [8:0] dy, dx, dd;
  logic signed [17:0] prod;
  logic [17:0]        prod_abs;
  logic [8:0]         dd_abs;

  always_comb begin
    upper    = lvl_q > user_def_q;
    dy       = upper ? ($signed({1'b0, panel_max_q}) - $signed({1'b0, panel_def_q}))
                     : ($signed({1'b0, panel_def_q}) - $signed({1'b0, panel_min_q}));
    dx       = upper ? ($signed({1'b0, lvl_q}) - $signed({1'b0, user_def_q}))
                     : ($signed({1'b0, lvl_q}) - $signed({1'b0, user_min_q}));
    dd       = upper ? ($signed({1'b0, user_max_q}) - $signed({1'b0, user_def_q}))
                     : ($signed({1'b0, user_def_q}) - $signed({1'b0, user_min_q}));
    prod     = dy * dx;
    prod_abs = prod[17] ? 18'(-prod) : 18'(prod);
    dd_abs   = dd[8] ? 9'(-dd) : 9'(dd);
  end

  // One restoring divider step
  logic [8:0]      trial;
  logic [8:0]      trial_sub;
  logic            ge;
  logic [7:0]      rem_d;
  logic [NumW-1:0] quo_d;

  always_comb begin
    trial     = {rem_q, quo_q[NumW-1]};
    trial_sub = trial - {1'b0, den_q};
    ge        = trial >= {1'b0, den_q};
    rem_d     = ge ? trial_sub[7:0] : trial[7:0];
    quo_d     = {quo_q[NumW-2:0], ge};
  end

  // Apply sign, add offset, clamp to 0..255
  logic signed [17:0] qs;
  logic signed [17:0] sum;
  logic [7:0]         clamp;

  always_comb begin
    qs  = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    sum = qs + $signed({10'd0, off_q});
    if (sum < 0) begin
      clamp = 8'd0;
    end else if (sum > 18'sd255) begin
      clamp = 8'd255;
    end else begin
      clamp = sum[7:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_def_q  <= RST_USER_DEFAULT;
      user_min_q  <= RST_USER_MINIMUM;
      user_max_q  <= RST_USER_MAXIMUM;
      panel_def_q <= RST_PANEL_DEFAULT;
      panel_min_q <= RST_PANEL_MINIMUM;
      panel_max_q <= RST_PANEL_MAXIMUM;
      dim_thr_q   <= RST_DIM_THRESHOLD;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.reg_idx)
        CFG_USER_DEFAULT:  user_def_q  <= cfg_i.wdata;
        CFG_USER_MINIMUM:  user_min_q  <= cfg_i.wdata;
        CFG_USER_MAXIMUM:  user_max_q  <= cfg_i.wdata;
        CFG_PANEL_DEFAULT: panel_def_q <= cfg_i.wdata;
        CFG_PANEL_MINIMUM: panel_min_q <= cfg_i.wdata;
        CFG_PANEL_MAXIMUM: panel_max_q <= cfg_i.wdata;
        CFG_DIM_THRESHOLD: dim_thr_q   <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      enabled_q <= 1'b0;
      last_q    <= 8'd0;
      dim_q     <= 1'b1;
      saved_q   <= RST_SAVED_LEVEL;
      wr_q      <= 1'b0;
      stat_q    <= ST_WRITTEN;
      slot_q    <= SLOT_MODE;
      is_on_q   <= 1'b0;
      cnt_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (req_e'(req_i.req_type))
              REQ_OFF: begin
                enabled_q <= 1'b0;
                last_q    <= 8'd0;
                wr_q      <= 1'b0;
                stat_q    <= ST_OFF;
                state_q   <= S_EMIT;
              end
              REQ_SET, REQ_ON: begin
                if (req_i.req_type == REQ_SET && !enabled_q) begin
                  wr_q    <= 1'b0;
                  stat_q  <= ST_GATED;
                  state_q <= S_EMIT;
                end else begin
                  is_on_q <= (req_i.req_type == REQ_ON);
                  if (req_i.req_type == REQ_ON) begin
                    enabled_q <= 1'b1;
                  end
                  lvl_q   <= (req_i.req_type == REQ_ON && req_i.level_request == 8'd0)
                             ? saved_q : req_i.level_request;
                  state_q <= S_RANGE;
                end
              end
              default: ;
            endcase
          end
        end
        S_RANGE: begin
          // Pick the piece; load the divider on the interpolating piece
          if (lvl_q < dim_thr_q) begin
            pl_q    <= 8'd0;
            state_q <= S_CMP;
          end else if (lvl_q < user_min_q) begin
            pl_q    <= panel_min_q;
            state_q <= S_CMP;
          end else if (dd_abs == 9'd0) begin
            pl_q    <= panel_def_q;
            state_q <= S_CMP;
          end else begin
            quo_q   <= prod_abs[NumW-1:0];
            rem_q   <= 8'd0;
            den_q   <= dd_abs[7:0];
            neg_q   <= prod[17] ^ dd[8];
            off_q   <= upper ? panel_def_q : panel_min_q;
            cnt_q   <= '1;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          quo_q <= quo_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          pl_q    <= clamp;
          state_q <= S_CMP;
        end
        S_CMP: begin
          // Skip an identical level, else commit and queue the writes;
          // an on request re-arms the dim write afterwards
          if (pl_q == last_q) begin
            wr_q   <= 1'b0;
            stat_q <= ST_SAME;
            if (is_on_q) begin
              dim_q <= 1'b1;
            end
          end else begin
            wr_q    <= 1'b1;
            stat_q  <= ST_WRITTEN;
            slot_q  <= dim_q ? SLOT_DIM : SLOT_MODE;
            dim_q   <= is_on_q;
            last_q  <= pl_q;
            saved_q <= lvl_q;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            if (!wr_q || slot_q == SLOT_LEVEL) begin
              state_q <= S_IDLE;
            end else begin
              slot_q <= slot_e'(slot_q + 2'd1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_wr_q   <= wr_q;
      out_stat_q <= stat_q;
      out_lvl_q  <= saved_q;
      out_last_q <= !wr_q || slot_q == SLOT_LEVEL;
      if (!wr_q) begin
        out_addr_q <= 16'd0;
        out_data_q <= 8'd0;
      end else begin
        case (slot_q)
          SLOT_DIM: begin
            out_addr_q <= ADDR_DIM;
            out_data_q <= DATA_DIM;
          end
          SLOT_MODE: begin
            out_addr_q <= ADDR_MODE;
            out_data_q <= DATA_MODE;
          end
          default: begin
            out_addr_q <= ADDR_LEVEL;
            out_data_q <= pl_q;
          end
        endcase
      end
    end
  end

  // Divider never runs on a zero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> den_q != 8'd0)
    else $error("divider running with zero divisor");

  // Partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < den_q)
    else $error("divider remainder out of range");

  // A beat without a panel write always ends its sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_wr_q |-> out_last_q)
    else $error("non-write beat not marked last");

  // A panel write always carries written status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_wr_q |-> out_stat_q == ST_WRITTEN)
    else $error("write beat with wrong status");

endmodule
